// ----- sv/dles_pkg.sv -----
// package for the drum loop event sequencer
// types, op codes and sizes shared by the front end, queue and back end
package dles_pkg;

  localparam int unsigned EventCapacity = 64;
  localparam int unsigned TimeW = 32;

  typedef enum logic [2:0] {
    OpStart  = 3'd0,
    OpStop   = 3'd1,
    OpHit    = 3'd2,
    OpTick   = 3'd3,
    OpClear  = 3'd4,
    OpToggle = 3'd5
  } op_e;

  // classified command handed from front end to back end
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] now;
    logic [7:0]  drum;
    logic [15:0] vel;
  } cmd_t;

  // status snapshot attached to each result item
  typedef struct packed {
    logic        rec;
    logic        play;
    logic        ovd;
    logic [31:0] len;
  } status_t;

endpackage

// ----- sv/drum_loop_event_sequencer.sv -----
// drum loop event sequencer: command fifo front end, executing back end
// the back end takes one command at a time and accepts the next only once back in idle;
// receiver stalls hold it up; the fifo holds 2 items
// reset: asynchronous active low; clears flags, counts and times, store left unwritten
module drum_loop_event_sequencer #(
  parameter int unsigned EVENT_CAPACITY = dles_pkg::EventCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // sample_time, drum_number, hit_velocity
  input  logic [2:0]  s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // trigger_drum, trigger_velocity, loop_length
  output logic [3:0]  m_axis_tuser,  // trigger_valid, is_recording, is_playing, overdub_on
  output logic        m_axis_tlast   // last_of_run
);
  // commands into the fifo and from the fifo to the back end
  dles_pkg::cmd_t in_cmd, q_cmd;
  dles_pkg::status_t stat;
  logic q_valid, q_ready;
  logic trig;
  logic [7:0] drum;
  logic [15:0] vel;

  assign in_cmd = '{op: s_axis_tuser, now: s_axis_tdata[31:0],
                    drum: s_axis_tdata[39:32], vel: s_axis_tdata[55:40]};

  dles_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_cmd_i(in_cmd),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  dles_back #(.EventCapacity(EVENT_CAPACITY)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_trig_o(trig), .out_drum_o(drum), .out_vel_o(vel),
    .out_last_o(m_axis_tlast), .out_stat_o(stat)
  );

  // pack result fields, lowest first
  assign m_axis_tdata = {stat.len, vel, drum};
  assign m_axis_tuser = {stat.ovd, stat.play, stat.rec, trig};
endmodule

// ----- sv/dles_front.sv -----
// front end: accepts command items and pushes them into a small fifo
// depends on dles_pkg
module dles_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dles_pkg::cmd_t in_cmd_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output dles_pkg::cmd_t q_cmd_o
);
  localparam int unsigned Depth = 2;

  dles_pkg::cmd_t mem_q [Depth];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;
  assign q_cmd_o = mem_q[rp_q];

  always_comb begin
    wp_d = push ? ~wp_q : wp_q;
    rp_d = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_cmd_i;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("fifo overflow");
  a_count_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("fifo count");
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("pop from empty");
`endif
endmodule

// ----- sv/dles_divu.sv -----
// radix-2 restoring remainder unit, one bit per cycle
// no package dependency
module dles_divu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] rem_o
);
  logic [31:0] num_q, num_d, den_q, den_d;
  logic [32:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] sh;

  assign rem_o  = rem_q[31:0];
  assign done_o = done_q;

  always_comb begin
    num_d = num_q;
    den_d = den_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sh = {rem_q[31:0], num_q[31]};
    if (start_i) begin
      num_d = num_i;
      den_d = den_i;
      rem_d = '0;
      cnt_d = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      rem_d = (sh >= {1'b0, den_q}) ? sh - {1'b0, den_q} : sh;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end
endmodule

// ----- sv/dles_back.sv -----
// back end: executes commands against the event store, scans on ticks
// depends on dles_pkg and dles_divu
module dles_back #(
  parameter int unsigned EventCapacity = dles_pkg::EventCapacity
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  dles_pkg::cmd_t  q_cmd_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            out_trig_o,
  output logic [7:0]      out_drum_o,
  output logic [15:0]     out_vel_o,
  output logic            out_last_o,
  output dles_pkg::status_t out_stat_o
);
  localparam int unsigned IdxW = (EventCapacity > 1) ? $clog2(EventCapacity) : 1;
  localparam int unsigned CntW = $clog2(EventCapacity + 1);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StDiv  = 6'b000010,
    StRead = 6'b000100,
    StTest = 6'b001000,
    StEmit = 6'b010000,
    StOne  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  dles_pkg::cmd_t cmd_q;
  logic [55:0] store_q [EventCapacity];
  logic [55:0] rd_q;
  logic [IdxW-1:0] ridx;
  logic [CntW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic rec_q, rec_d, play_q, play_d, ovd_q, ovd_d;
  logic [31:0] len_q, len_d, start_q, start_d, lpos_q, lpos_d, pos_q, pos_d;
  logic pend_v_q, pend_v_d;
  logic [7:0] pend_drum_q, pend_drum_d;
  logic [15:0] pend_vel_q, pend_vel_d;
  logic div_start, div_done;
  logic [31:0] div_rem, rel;
  logic wr_en;
  logic [31:0] wr_when;
  logic hit, more, ob_full;
  logic [31:0] t;
  dles_pkg::status_t cur_stat;

  // output buffer
  logic ob_v_q, ob_v_d, ob_trig_q, ob_trig_d, ob_last_q, ob_last_d;
  logic [7:0] ob_drum_q, ob_drum_d;
  logic [15:0] ob_vel_q, ob_vel_d;
  dles_pkg::status_t ob_stat_q, ob_stat_d;

  dles_divu u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(rel), .den_i(len_q),
    .done_o(div_done), .rem_o(div_rem)
  );

  // the remainder starts in idle, when the command is still at the queue head
  assign rel = q_cmd_i.now - start_q;
  assign ob_full = ob_v_q && !out_ready_i;
  assign q_ready_o = (state_q == StIdle);
  assign ridx = idx_q[IdxW-1:0];
  assign t = rd_q[55:24];
  assign more = (idx_q + 1'b1) < cnt_q;
  assign cur_stat = '{rec: rec_q, play: play_q, ovd: ovd_q, len: len_q};

  always_comb begin
    if (lpos_q < pos_q) hit = (t > lpos_q) && (t <= pos_q);
    else if (pos_q < lpos_q) hit = (t > lpos_q) || (t <= pos_q);
    else hit = (t == pos_q);
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; idx_d = idx_q;
    rec_d = rec_q; play_d = play_q; ovd_d = ovd_q;
    len_d = len_q; start_d = start_q; lpos_d = lpos_q; pos_d = pos_q;
    pend_v_d = pend_v_q; pend_drum_d = pend_drum_q; pend_vel_d = pend_vel_q;
    div_start = 1'b0;
    wr_en = 1'b0;
    wr_when = rel;
    ob_v_d = ob_v_q && !out_ready_i;
    ob_trig_d = ob_trig_q; ob_last_d = ob_last_q;
    ob_drum_d = ob_drum_q; ob_vel_d = ob_vel_q;
    ob_stat_d = ob_stat_q;
    unique case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          state_d = StOne;
          unique case (q_cmd_i.op)
            dles_pkg::OpStart: begin
              cnt_d = '0; rec_d = 1'b1; play_d = 1'b0;
              start_d = '0; lpos_d = '0;
            end
            dles_pkg::OpStop: begin
              rec_d = 1'b0;
              len_d = (start_q != '0) ? q_cmd_i.now - start_q : '0;
              play_d = !(cnt_q == '0 || len_d == '0);
              lpos_d = '0;
            end
            dles_pkg::OpHit: begin
              if (rec_q) begin
                if (start_q == '0 && cnt_q == '0) start_d = q_cmd_i.now;
                if (start_d != '0) begin
                  if (cnt_q < CntW'(EventCapacity)) begin
                    wr_en = 1'b1;
                    wr_when = q_cmd_i.now - start_d;
                    cnt_d = cnt_q + 1'b1;
                  end else begin
                    rec_d = 1'b0;
                    len_d = q_cmd_i.now - start_q;
                    play_d = (len_d != '0);
                    lpos_d = '0;
                  end
                end
              end else if (play_q && ovd_q && len_q != '0 && start_q != '0
                           && cnt_q < CntW'(EventCapacity)) begin
                state_d = StDiv;
              end
            end
            dles_pkg::OpTick: begin
              if (play_q && len_q != '0 && cnt_q != '0 && start_q != '0)
                state_d = StDiv;
            end
            dles_pkg::OpClear: begin
              cnt_d = '0; play_d = 1'b0; rec_d = 1'b0;
              len_d = '0; start_d = '0; lpos_d = '0;
            end
            dles_pkg::OpToggle: ovd_d = !ovd_q;
            default: ;
          endcase
          if (state_d == StDiv) div_start = 1'b1;
        end
      end
      StDiv: begin
        if (div_done) begin
          if (cmd_q.op == dles_pkg::OpHit) begin
            wr_en = 1'b1;
            wr_when = div_rem;
            cnt_d = cnt_q + 1'b1;
            state_d = StOne;
          end else begin
            pos_d = div_rem;
            idx_d = '0;
            pend_v_d = 1'b0;
            state_d = StRead;
          end
        end
      end
      StRead: state_d = StTest;
      StTest: begin
        // a held hit goes out only once a newer one shows it was not the last
        if (!(hit && pend_v_q && ob_full)) begin
          if (hit) begin
            if (pend_v_q) begin
              ob_v_d = 1'b1; ob_trig_d = 1'b1;
              ob_drum_d = pend_drum_q; ob_vel_d = pend_vel_q;
              ob_last_d = 1'b0;
              ob_stat_d = cur_stat;
            end
            pend_v_d = 1'b1;
            pend_drum_d = rd_q[23:16]; pend_vel_d = rd_q[15:0];
          end
          if (more) begin
            idx_d = idx_q + 1'b1; state_d = StRead;
          end else begin
            lpos_d = pos_q;
            state_d = (hit || pend_v_q) ? StEmit : StOne;
          end
        end
      end
      StEmit: begin
        if (!ob_full) begin
          ob_v_d = 1'b1; ob_trig_d = 1'b1;
          ob_drum_d = pend_drum_q; ob_vel_d = pend_vel_q;
          ob_last_d = 1'b1;
          ob_stat_d = cur_stat;
          state_d = StIdle;
        end
      end
      StOne: begin
        if (!ob_full) begin
          ob_v_d = 1'b1; ob_trig_d = 1'b0; ob_drum_d = '0; ob_vel_d = '0;
          ob_last_d = 1'b1;
          ob_stat_d = cur_stat;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // the last hit of a tick is held until the scan ends, so it carries the last flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0; idx_q <= '0;
      rec_q <= 1'b0; play_q <= 1'b0; ovd_q <= 1'b0;
      len_q <= '0; start_q <= '0; lpos_q <= '0;
      ob_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d; idx_q <= idx_d;
      rec_q <= rec_d; play_q <= play_d; ovd_q <= ovd_d;
      len_q <= len_d; start_q <= start_d; lpos_q <= lpos_d;
      ob_v_q <= ob_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && q_valid_i) cmd_q <= q_cmd_i;
    pos_q <= pos_d;
    pend_v_q <= pend_v_d; pend_drum_q <= pend_drum_d; pend_vel_q <= pend_vel_d;
    ob_trig_q <= ob_trig_d; ob_last_q <= ob_last_d;
    ob_drum_q <= ob_drum_d; ob_vel_q <= ob_vel_d;
    ob_stat_q <= ob_stat_d;
    if (wr_en) store_q[cnt_q[IdxW-1:0]] <= {wr_when,
      (state_q == StIdle) ? q_cmd_i.drum : cmd_q.drum,
      (state_q == StIdle) ? q_cmd_i.vel : cmd_q.vel};
    rd_q <= store_q[ridx];
  end

  assign out_valid_o = ob_v_q;
  assign out_trig_o = ob_trig_q;
  assign out_drum_o = ob_drum_q;
  assign out_vel_o = ob_vel_q;
  assign out_last_o = ob_last_q;
  assign out_stat_o = ob_stat_q;

`ifndef ASSERT_OFF
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(EventCapacity)) else $error("event count beyond capacity");
  a_ob_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_v_q && !out_ready_i |=> ob_v_q && $stable(ob_drum_q)) else $error("result lost");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ready_o |-> state_q == StIdle) else $error("accept while busy");
`endif
endmodule

// ----- tb/drum_loop_event_sequencer_tb.sv -----
// testbench for the drum loop event sequencer
// drives commands on the input stream and checks trigger and status items against a predictor
// depends on dles_pkg and drum_loop_event_sequencer
module drum_loop_event_sequencer_tb;

  localparam int unsigned Cap = dles_pkg::EventCapacity;
  localparam int unsigned CycleLimit = 1500000;

  // one expected result item
  typedef struct packed {
    logic        fire;
    logic [7:0]  drum;
    logic [15:0] vel;
    logic        last;
    logic        rec;
    logic        play;
    logic        ovd;
    logic [31:0] len;
  } trig_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;  // sample_time, drum_number, hit_velocity
  logic [2:0]  s_axis_tuser;  // op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;  // trigger_drum, trigger_velocity, loop_length
  logic [3:0]  m_axis_tuser;  // trigger_valid, is_recording, is_playing, overdub_on
  logic        m_axis_tlast;  // last_of_run

  drum_loop_event_sequencer dut (.*);

  // predictor state, mirrors the block
  logic [31:0] loop_when [Cap];
  logic [7:0]  loop_drum [Cap];
  logic [15:0] loop_vel  [Cap];
  int unsigned loop_count;
  logic        rec_on, play_on, ovd_on;
  logic [31:0] loop_len, loop_start, last_pos;

  trig_t       pending_trigs[$];
  int          mismatches;
  int          send_idle_pct, recv_idle_pct;
  longint      cycles;
  logic [31:0] clock_now;  // running sample clock for stimulus

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // cycle limit guards against a hung block
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void stop_loop(logic [31:0] now);
    rec_on   = 1'b0;
    play_on  = 1'b1;
    loop_len = (loop_start != '0) ? now - loop_start : 32'd0;
    if (loop_count == 0 || loop_len == '0) play_on = 1'b0;
    last_pos = '0;
  endfunction

  function automatic void push_trig(logic fire, logic [7:0] d, logic [15:0] v);
    trig_t t;
    t.fire = fire; t.drum = d; t.vel = v; t.last = 1'b0;
    t.rec = rec_on; t.play = play_on; t.ovd = ovd_on; t.len = loop_len;
    pending_trigs.push_back(t);
  endfunction

  // works out the result items of one command and queues them
  function automatic void predict_command(logic [2:0] op, logic [31:0] now,
                                          logic [7:0] d, logic [15:0] v);
    int          n;
    logic [31:0] rel, pos, lp, t;
    logic        hit, skip;
    n = 0;
    rel = '0;
    case (op)
      dles_pkg::OpStart: begin
        loop_count = 0; rec_on = 1'b1; play_on = 1'b0; loop_start = '0; last_pos = '0;
      end
      dles_pkg::OpStop: stop_loop(now);
      dles_pkg::OpHit: begin
        skip = 1'b0;
        if (!rec_on && !(play_on && ovd_on)) skip = 1'b1;
        else if (rec_on) begin
          if (loop_start == '0 && loop_count == 0) loop_start = now;
          if (loop_start == '0) skip = 1'b1;
          rel = now - loop_start;
        end else begin
          if (loop_len == '0 || loop_start == '0) skip = 1'b1;
          else rel = (now - loop_start) % loop_len;
        end
        if (!skip) begin
          if (loop_count < Cap) begin
            loop_when[loop_count] = rel;
            loop_drum[loop_count] = d;
            loop_vel[loop_count]  = v;
            loop_count++;
          end else if (rec_on) stop_loop(now);
        end
      end
      dles_pkg::OpTick: begin
        if (play_on && loop_len != '0 && loop_count != 0 && loop_start != '0) begin
          pos = (now - loop_start) % loop_len;
          lp  = last_pos;
          for (int i = 0; i < loop_count; i++) begin
            t = loop_when[i];
            if (lp < pos) hit = (t > lp) && (t <= pos);
            else if (pos < lp) hit = (t > lp) || (t <= pos);
            else hit = (t == pos);
            if (hit) begin
              push_trig(1'b1, loop_drum[i], loop_vel[i]);
              n++;
            end
          end
          last_pos = pos;
        end
      end
      dles_pkg::OpClear: begin
        loop_count = 0; play_on = 1'b0; rec_on = 1'b0;
        loop_len = '0; loop_start = '0; last_pos = '0;
      end
      dles_pkg::OpToggle: ovd_on = ~ovd_on;
      default: ;
    endcase
    if (n == 0) push_trig(1'b0, 8'd0, 16'd0);
    pending_trigs[$].last = 1'b1;
  endfunction

  // sends one command item, with random gaps before it
  task automatic send_command(logic [2:0] op, logic [31:0] now,
                              logic [7:0] d = 8'd0, logic [15:0] v = 16'd0);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {v, d, now};
    predict_command(op, now, d, v);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver stalls at random
  always @(negedge clk_i)
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  // checks each result item against the oldest expectation
  always @(posedge clk_i) begin
    trig_t exp_t;
    trig_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.fire = m_axis_tuser[0]; got.rec = m_axis_tuser[1];
      got.play = m_axis_tuser[2]; got.ovd = m_axis_tuser[3];
      got.drum = m_axis_tdata[7:0]; got.vel = m_axis_tdata[23:8];
      got.len  = m_axis_tdata[55:24]; got.last = m_axis_tlast;
      if (pending_trigs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", got);
      end else begin
        exp_t = pending_trigs.pop_front();
        if (got != exp_t) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_t, got);
        end
      end
    end
  end

  // advances the stimulus sample clock, skipping zero
  function automatic logic [31:0] step_clock(int unsigned span);
    clock_now = clock_now + span;
    if (clock_now == '0) clock_now = 32'd1;
    return clock_now;
  endfunction

  task automatic test_directed();
    send_command(3'd6, 32'hFFFF_FFFF);
    send_command(3'd7, 32'd0, 8'hFF, 16'hFFFF);
    send_command(dles_pkg::OpHit, 32'd100, 8'd1, 16'd1);   // ignored while idle
    send_command(dles_pkg::OpStop, 32'd50);                // stop while not recording
    send_command(dles_pkg::OpStart, 32'd0);
    send_command(dles_pkg::OpHit, 32'd0, 8'hFF, 16'hFFFF); // hit at sample zero dropped
    send_command(dles_pkg::OpHit, 32'hFFFF_FFF0, 8'hFF, 16'hFFFF);
    send_command(dles_pkg::OpHit, 32'hFFFF_FFF8, 8'h00, 16'h0000);
    send_command(dles_pkg::OpHit, 32'h0000_0004, 8'hA5, 16'h5A5A); // wraps
    send_command(dles_pkg::OpStop, 32'h0000_0010);
    send_command(dles_pkg::OpTick, 32'hFFFF_FFF0);  // equal position
    send_command(dles_pkg::OpTick, 32'h0000_0008);
    send_command(dles_pkg::OpTick, 32'hFFFF_FFF4);  // window wraps
    send_command(dles_pkg::OpToggle, 32'd0);
    send_command(dles_pkg::OpHit, 32'h1234_5678, 8'h3C, 16'h8001); // overdub fold
    send_command(dles_pkg::OpTick, 32'h1234_5678);
    send_command(dles_pkg::OpToggle, 32'd0);
    send_command(dles_pkg::OpClear, 32'd0);
    send_command(dles_pkg::OpStart, 32'd0);
    send_command(dles_pkg::OpStop, 32'd500);        // empty loop
    send_command(dles_pkg::OpClear, 32'd0);
  endtask

  // fills the store past capacity while recording, then in overdub
  task automatic test_full_store();
    logic [31:0] base;
    base = step_clock(1000);
    send_command(dles_pkg::OpStart, base);
    for (int i = 0; i <= Cap; i++)
      send_command(dles_pkg::OpHit, step_clock($urandom_range(1, 20)),
                   8'($urandom), 16'($urandom));
    send_command(dles_pkg::OpTick, step_clock(7));
    send_command(dles_pkg::OpToggle, 32'd0);
    send_command(dles_pkg::OpHit, step_clock(3), 8'($urandom), 16'($urandom));
    send_command(dles_pkg::OpTick, step_clock(400));
    send_command(dles_pkg::OpToggle, 32'd0);
  endtask

  // mostly record, stop, tick sessions with random content, plus noise
  task automatic test_random_loops(int items);
    int sent;
    int kind;
    sent = 0;
    while (sent < items) begin
      kind = $urandom_range(9);
      if (kind < 7) begin
        send_command(dles_pkg::OpStart, $urandom);
        sent++;
        repeat ($urandom_range(1, 8)) begin
          send_command(dles_pkg::OpHit, step_clock($urandom_range(1, 60)),
                       8'($urandom), 16'($urandom));
          sent++;
        end
        send_command(dles_pkg::OpStop, step_clock($urandom_range(1, 60)));
        sent++;
        if ($urandom_range(2) == 0) begin
          send_command(dles_pkg::OpToggle, $urandom);
          sent++;
        end
        repeat ($urandom_range(2, 8)) begin
          if (ovd_on && $urandom_range(3) == 0)
            send_command(dles_pkg::OpHit, step_clock($urandom_range(1, 90)),
                         8'($urandom), 16'($urandom));
          else
            send_command(dles_pkg::OpTick, step_clock($urandom_range(0, 90)));
          sent++;
        end
      end else begin
        send_command(3'($urandom_range(7)), $urandom, 8'($urandom), 16'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    int wait_cycles;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cycles = 0;
    mismatches = 0;
    clock_now = 32'd1;
    loop_count = 0; rec_on = 1'b0; play_on = 1'b0; ovd_on = 1'b0;
    loop_len = '0; loop_start = '0; last_pos = '0;
    send_idle_pct = 28; recv_idle_pct = 53;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_full_store();
    test_random_loops(70);
    send_idle_pct = 53; recv_idle_pct = 28;
    test_random_loops(70);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_loops(70);
    s_axis_tvalid = 1'b0;

    wait_cycles = 0;
    while (pending_trigs.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && pending_trigs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
